// ===== sv/lmfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfe_pkg
// Shared sizes, command codes and the store request type of the LED matrix
// framebuffer engine.
// ----------------------------------------------------------------------------
package lmfe_pkg;

    localparam int COLUMNS = 128;
    localparam int ROWS    = 32;

    localparam int COL_AW  = $clog2(COLUMNS);
    localparam int ROW_AW  = $clog2(ROWS);
    localparam int GROUPS  = ((COLUMNS / 8) > 16) ? 16 : (COLUMNS / 8);

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_FILL  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic              rd_en;
        logic [COL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [COL_AW-1:0] wr_addr;
        logic [ROWS-1:0]   wr_data;
    } mem_req_t;

endpackage

// ===== sv/lmfe_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfe_store
// Column store with one write and one registered read port. A column that
// has not been written since reset reads as zero.
// ----------------------------------------------------------------------------
module lmfe_store (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lmfe_pkg::mem_req_t                 req,
    output logic [lmfe_pkg::ROWS-1:0]          rd_data
);

    logic [lmfe_pkg::ROWS-1:0]    mem [lmfe_pkg::COLUMNS];
    logic [lmfe_pkg::COLUMNS-1:0] written_reg;
    logic [lmfe_pkg::ROWS-1:0]    data_q_reg;
    logic                         written_q_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            data_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                written_q_reg <= written_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = written_q_reg ? data_q_reg : '0;

endmodule

// ===== sv/led_matrix_framebuffer_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_framebuffer_engine
// Column-organized LED framebuffer with put-column, clear/fill area and
// row readout commands, run by a small sequencer over one column store.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    command, window, limits, glyph column
// m_       out        m_valid/m_ready    row_byte, group_index, wrote, last
//
// Put column runs in order: accept, column read, column write, result.
// Clear and fill walk the columns of the area, one store column a cycle.
// Read row builds each byte from eight column reads, then waits for the
// result handshake; 16 bytes. The store port is the limit: one read and one write per cycle.
// Reset clears all per-column written flags together; no clearing pass.
// The input is not ready while a command runs; a stalled result holds it.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [6:0]  s_x_first,
    input  logic [7:0]  s_x_last,
    input  logic [4:0]  s_row_low,
    input  logic [4:0]  s_row_high,
    input  logic [7:0]  s_right_limit,
    input  logic [31:0] s_column_bits,
    input  logic [4:0]  s_row_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_row_byte,
    output logic [3:0]  m_group_index,
    output logic        m_wrote,
    output logic        m_last
);

    localparam int CA = lmfe_pkg::COL_AW;
    localparam int RW = lmfe_pkg::ROWS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUT_RD,
        ST_PUT_WR,
        ST_AREA,
        ST_READ,
        ST_OUT
    } state_t;

    state_t                 state_reg;
    lmfe_pkg::cmd_t         cmd;
    logic [RW-1:0]          win_reg;
    logic [RW-1:0]          glyph_reg;
    logic                   fill_reg;
    logic [CA:0]            col_reg;
    logic [CA:0]            end_reg;
    logic [4:0]             row_reg;
    logic [7:0]             byte_reg;
    logic [3:0]             issue_cnt_reg;
    logic [2:0]             ret_cnt_reg;
    logic                   rvalid_reg;
    logic [3:0]             group_reg;
    logic                   wb_reg;
    logic [CA-1:0]          wb_addr_reg;
    logic                   m_valid_reg;
    logic [7:0]             m_row_byte_reg;
    logic [3:0]             m_group_index_reg;
    logic                   m_wrote_reg;
    logic                   m_last_reg;

    logic [31:0]            win_full;
    logic [31:0]            glyph_full;
    logic                   win_empty;
    logic [8:0]             end_full;
    logic                   put_ok;
    logic                   area_go;
    logic                   area_issue;
    logic                   read_issue;
    logic                   row_ok;
    logic                   row_bit;
    logic [RW-1:0]          rd_data;
    lmfe_pkg::mem_req_t     mem_req;

    assign cmd = lmfe_pkg::cmd_t'(s_command);

    always_comb begin
        win_full   = (32'hFFFFFFFF << s_row_low) & (32'hFFFFFFFF >> (5'd31 - s_row_high));
        glyph_full = (s_column_bits << s_row_low) & win_full;
        win_empty  = s_row_low > s_row_high;
        end_full   = (9'(s_x_last) > 9'(lmfe_pkg::COLUMNS - 1)) ?
                     9'(lmfe_pkg::COLUMNS - 1) : 9'(s_x_last);
        put_ok     = !win_empty && ({1'b0, s_x_first} <= s_right_limit) &&
                     (9'(s_x_first) < 9'(lmfe_pkg::COLUMNS));
        area_go    = !win_empty && (9'(s_x_first) <= end_full);
    end

    assign area_issue = col_reg <= end_reg;
    assign read_issue = !issue_cnt_reg[3];
    assign row_ok     = {1'b0, row_reg} < 6'(lmfe_pkg::ROWS);
    assign row_bit    = row_ok ? rd_data[row_reg[lmfe_pkg::ROW_AW-1:0]] : 1'b0;

    always_comb begin
        mem_req         = '0;
        mem_req.rd_addr = col_reg[CA-1:0];
        mem_req.wr_addr = wb_addr_reg;
        unique case (state_reg)
            ST_PUT_RD: begin
                mem_req.rd_en = 1'b1;
            end
            ST_PUT_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = col_reg[CA-1:0];
                mem_req.wr_data = (rd_data & ~win_reg) | glyph_reg;
            end
            ST_AREA: begin
                mem_req.rd_en   = area_issue;
                mem_req.wr_en   = wb_reg;
                mem_req.wr_data = (rd_data & ~win_reg) | (fill_reg ? win_reg : '0);
            end
            ST_READ: begin
                mem_req.rd_en = read_issue;
            end
            default: begin
                mem_req.rd_en = 1'b0;
            end
        endcase
    end

    lmfe_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            wb_reg      <= 1'b0;
            rvalid_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        win_reg        <= win_full[RW-1:0];
                        glyph_reg      <= glyph_full[RW-1:0];
                        fill_reg       <= cmd == lmfe_pkg::CMD_FILL;
                        col_reg        <= (cmd == lmfe_pkg::CMD_READ) ?
                                          '0 : (CA + 1)'(s_x_first);
                        end_reg        <= (CA + 1)'(end_full);
                        row_reg        <= s_row_index;
                        wb_reg         <= 1'b0;
                        m_row_byte_reg    <= 8'd0;
                        m_group_index_reg <= 4'd0;
                        m_wrote_reg       <= 1'b0;
                        m_last_reg        <= 1'b1;
                        unique case (cmd)
                            lmfe_pkg::CMD_PUT: begin
                                if (put_ok) begin
                                    state_reg <= ST_PUT_RD;
                                end else begin
                                    m_valid_reg <= 1'b1;
                                    state_reg   <= ST_OUT;
                                end
                            end
                            lmfe_pkg::CMD_CLEAR, lmfe_pkg::CMD_FILL: begin
                                if (area_go) begin
                                    state_reg <= ST_AREA;
                                end else begin
                                    m_valid_reg <= 1'b1;
                                    state_reg   <= ST_OUT;
                                end
                            end
                            lmfe_pkg::CMD_READ: begin
                                issue_cnt_reg <= 4'd0;
                                ret_cnt_reg   <= 3'd0;
                                rvalid_reg    <= 1'b0;
                                group_reg     <= 4'd0;
                                state_reg     <= ST_READ;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_PUT_RD: begin
                    state_reg <= ST_PUT_WR;
                end
                ST_PUT_WR: begin
                    m_wrote_reg <= 1'b1;
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_OUT;
                end
                ST_AREA: begin
                    wb_reg      <= area_issue;
                    wb_addr_reg <= col_reg[CA-1:0];
                    if (area_issue) begin
                        col_reg <= col_reg + 1'b1;
                    end else if (!wb_reg) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_READ: begin
                    rvalid_reg <= read_issue;
                    if (read_issue) begin
                        col_reg       <= col_reg + 1'b1;
                        issue_cnt_reg <= issue_cnt_reg + 4'd1;
                    end
                    if (rvalid_reg) begin
                        byte_reg    <= {row_bit, byte_reg[7:1]};
                        ret_cnt_reg <= ret_cnt_reg + 3'd1;
                        if (ret_cnt_reg == 3'd7) begin
                            m_row_byte_reg    <= {row_bit, byte_reg[7:1]};
                            m_group_index_reg <= group_reg;
                            m_wrote_reg       <= 1'b0;
                            m_last_reg        <= group_reg == 4'(lmfe_pkg::GROUPS - 1);
                            m_valid_reg       <= 1'b1;
                            state_reg         <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            issue_cnt_reg <= 4'd0;
                            ret_cnt_reg   <= 3'd0;
                            rvalid_reg    <= 1'b0;
                            group_reg     <= group_reg + 4'd1;
                            state_reg     <= ST_READ;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready       = state_reg == ST_IDLE;
    assign m_valid       = m_valid_reg;
    assign m_row_byte    = m_row_byte_reg;
    assign m_group_index = m_group_index_reg;
    assign m_wrote       = m_wrote_reg;
    assign m_last        = m_last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input ready while a result item is pending.");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == ST_PUT_WR || state_reg == ST_AREA))
        else $error("Store written outside a put or area command.");

    a_wrote_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_wrote) |-> (m_last && m_group_index == 4'd0 && m_row_byte == 8'd0))
        else $error("Put result item is not a plain acknowledge.");

    a_area_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_AREA && !area_issue && !wb_reg) |=> m_valid)
        else $error("Area command finished without a result item.");

endmodule
